@@ hw/rtl/u8d_pkg.sv @@
package u8d_pkg;

	// Field widths of the input item and the result item
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned REM_W  = 2;
	localparam int unsigned PART_W = 15;
	localparam int unsigned PAY_W  = 7;

	// Default queue depths
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;
	localparam int unsigned RESULT_DEPTH_DEF = 4;

	// Byte class codes, set by the front end
	localparam logic [1:0] KIND_ASCII = 2'd0;
	localparam logic [1:0] KIND_LEAD  = 2'd1;
	localparam logic [1:0] KIND_CONT  = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	// Masks and patterns for the byte classes
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_PAT   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;
	localparam logic [7:0] CONT_BITS  = 8'h3F;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		logic             error;
	} out_item_t;

	// Classified byte travelling from the front end to the back end
	typedef struct packed {
		logic [1:0]       kind;
		logic [REM_W-1:0] lead_len;   // continuation bytes a lead opens
		logic [PAY_W-1:0] payload;    // code point bits carried by the byte
		logic             last;
	} cls_t;

endpackage

@@ hw/rtl/utf8_stream_decoder.sv @@
// Channel   Ports                    Transfer when
// ------    -----------------------  -----------------------
// bytes     push, full, item         push high, full low
// results   empty, pop, result       pop high, empty low
//
// One byte is taken per cycle while full is low; the back end retires one classified
// byte per cycle from the byte queue while the result queue has room.
// A result reaches the result ports once the byte that completes or breaks a sequence
// has passed the front stage register, the byte queue and the result queue.
// Reset (arst_n low) empties both queues and returns the decoder to idle at once.
// A stalled result side fills the result queue, then the byte queue, then raises full.
module utf8_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH  = u8d_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned RESULT_DEPTH = u8d_pkg::RESULT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8d_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output u8d_pkg::out_item_t result
);

	import u8d_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	cls_t      q_wdata;
	cls_t      q_rdata;
	logic      res_push;
	logic      res_full;
	out_item_t res_wdata;

	// Classifier front end
	u8d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	// Queue of classified bytes
	u8d_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.T     (cls_t)
	) u_byte_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Sequence decoder back end
	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_wdata)
	);

	// Result queue facing the consumer
	u8d_fifo #(
		.DEPTH (RESULT_DEPTH),
		.T     (out_item_t)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

@@ hw/rtl/u8d_fifo.sv @@
module u8d_fifo #(
	parameter int unsigned DEPTH = 4,
	parameter type         T     = logic [7:0]
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage, written on a push transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo empty with pointers apart");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count missed a push");

endmodule

@@ hw/rtl/u8d_front.sv @@
module u8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8d_pkg::in_item_t item,
	output logic              full,
	output logic              q_push,
	output u8d_pkg::cls_t     q_data,
	input  logic              q_full
);

	import u8d_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic take;
	logic move;

	// Stage holds one classified byte until the queue takes it
	assign move   = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_push = valid_s1;
	assign q_data = cls_s1;

	// Classify the byte and extract its payload bits
	always_comb begin
		cls_d.last     = item.end_of_text;
		cls_d.lead_len = '0;
		cls_d.payload  = '0;
		if (item.byte_in <= ASCII_MAX) begin
			cls_d.kind    = KIND_ASCII;
			cls_d.payload = item.byte_in[PAY_W-1:0];
		end else if ((item.byte_in & CONT_MASK) == CONT_PAT) begin
			cls_d.kind    = KIND_CONT;
			cls_d.payload = PAY_W'(item.byte_in & CONT_BITS);
		end else if ((item.byte_in & LEAD2_MASK) == LEAD2_PAT) begin
			cls_d.kind     = KIND_LEAD;
			cls_d.lead_len = REM_W'(1);
			cls_d.payload  = PAY_W'(item.byte_in & LEAD2_BITS);
		end else if ((item.byte_in & LEAD3_MASK) == LEAD3_PAT) begin
			cls_d.kind     = KIND_LEAD;
			cls_d.lead_len = REM_W'(2);
			cls_d.payload  = PAY_W'(item.byte_in & LEAD3_BITS);
		end else if ((item.byte_in & LEAD4_MASK) == LEAD4_PAT) begin
			cls_d.kind     = KIND_LEAD;
			cls_d.lead_len = REM_W'(3);
			cls_d.payload  = PAY_W'(item.byte_in & LEAD4_BITS);
		end else begin
			cls_d.kind = KIND_BAD;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_full) |=> (valid_s1 && $stable(cls_s1)))
		else $error("front stage lost a stalled byte");

	a_lead_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cls_s1.kind == KIND_LEAD) |-> (cls_s1.lead_len != '0))
		else $error("lead byte without continuation count");

	a_take_moves: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted byte not in front stage");

endmodule

@@ hw/rtl/u8d_back.sv @@
module u8d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  u8d_pkg::cls_t      q_data,
	output logic               q_pop,
	input  logic               res_full,
	output logic               res_push,
	output u8d_pkg::out_item_t res
);

	import u8d_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [PART_W-1:0] partial_q;
	logic [LEN_W-1:0]  total_q;
	logic [REM_W-1:0]  rem_d;
	logic [PART_W-1:0] partial_d;
	logic [LEN_W-1:0]  total_d;
	logic [CP_W-1:0]   value;
	logic [REM_W-1:0]  rem_dec;

	// One classified byte per cycle while there is room for a result
	assign q_pop   = !q_empty && !res_full;
	assign value   = {partial_q, q_data.payload[5:0]};
	assign rem_dec = rem_q - 1'b1;

	// Sequence state update and result generation
	always_comb begin
		rem_d     = rem_q;
		partial_d = partial_q;
		total_d   = total_q;
		res_push  = 1'b0;
		res       = '0;
		if (q_pop) begin
			if (rem_q == '0) begin
				unique case (q_data.kind)
					KIND_ASCII: begin
						res_push       = 1'b1;
						res.code_point = CP_W'(q_data.payload);
						res.seq_length = LEN_W'(1);
					end
					KIND_LEAD: begin
						if (q_data.last) begin
							res_push  = 1'b1;
							res.error = 1'b1;
						end else begin
							rem_d     = q_data.lead_len;
							total_d   = LEN_W'(q_data.lead_len) + 1'b1;
							partial_d = PART_W'(q_data.payload);
						end
					end
					default: begin
						res_push  = 1'b1;
						res.error = 1'b1;
					end
				endcase
			end else if (q_data.kind != KIND_CONT) begin
				// expected a continuation: drop the byte and go idle
				res_push  = 1'b1;
				res.error = 1'b1;
				rem_d     = '0;
				partial_d = '0;
				total_d   = '0;
			end else if (rem_dec == '0) begin
				res_push       = 1'b1;
				res.code_point = value;
				res.seq_length = total_q;
				rem_d          = '0;
				partial_d      = '0;
				total_d        = '0;
			end else if (q_data.last) begin
				// string ends mid-sequence
				res_push  = 1'b1;
				res.error = 1'b1;
				rem_d     = '0;
				partial_d = '0;
				total_d   = '0;
			end else begin
				rem_d     = rem_dec;
				partial_d = value[PART_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			partial_q <= '0;
			total_q   <= '0;
		end else begin
			rem_q     <= rem_d;
			partial_q <= partial_d;
			total_q   <= total_d;
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0) |-> (total_q == '0 && partial_q == '0))
		else $error("idle with sequence state left over");

	a_len_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> (total_q > LEN_W'(rem_q) && total_q <= LEN_W'(4)))
		else $error("sequence length and count disagree");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.error) |-> (res.code_point == '0 && res.seq_length == '0))
		else $error("error result carries a value");

	a_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> q_pop)
		else $error("result without a consumed byte");

endmodule

@@ test/utf8_stream_decoder_chk.sv @@
`timescale 1ns / 100ps

// Watches both channels of the decoder, predicts each result from the
// accepted bytes and compares every result transfer with the oldest prediction.
module utf8_stream_decoder_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  u8d_pkg::in_item_t  item,
	input  logic               empty,
	input  logic               pop,
	input  u8d_pkg::out_item_t result,
	output int unsigned        fail_count,
	output int unsigned        pending
);
	import u8d_pkg::*;

	// Predicted decoder state
	logic [REM_W-1:0]  seq_left;
	logic [PART_W-1:0] seq_bits;
	logic [LEN_W-1:0]  seq_len;

	// Predicted characters and errors, oldest first
	out_item_t expected_chars [$];

	// One byte through the predicted decoder; emit is set when a result is due
	task automatic decode_byte(input in_item_t it, output bit emit, output out_item_t res);
		logic [7:0]      b;
		logic [CP_W-1:0] value;
		bit              broken;
		b      = it.byte_in;
		broken = 1'b0;
		emit   = 1'b0;
		res    = '0;
		if (seq_left == '0) begin
			if (b <= ASCII_MAX) begin
				// single byte, end flag has no effect
				emit           = 1'b1;
				res.code_point = CP_W'(b);
				res.seq_length = LEN_W'(1);
			end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
				seq_bits = PART_W'(b & LEAD2_BITS);
				seq_left = REM_W'(1);
				seq_len  = LEN_W'(2);
			end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
				seq_bits = PART_W'(b & LEAD3_BITS);
				seq_left = REM_W'(2);
				seq_len  = LEN_W'(3);
			end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
				seq_bits = PART_W'(b & LEAD4_BITS);
				seq_left = REM_W'(3);
				seq_len  = LEN_W'(4);
			end else begin
				broken = 1'b1;
			end
			// lead byte flagged as the end of the string: truncated
			if (!emit && it.end_of_text)
				broken = 1'b1;
		end else if ((b & CONT_MASK) != CONT_PAT) begin
			// not a continuation: dropped, not taken as a new lead
			broken = 1'b1;
		end else begin
			value    = {seq_bits, b[5:0]};
			seq_left = seq_left - 1'b1;
			if (seq_left == '0) begin
				emit           = 1'b1;
				res.code_point = value;
				res.seq_length = seq_len;
				seq_bits       = '0;
				seq_len        = '0;
			end else begin
				seq_bits = value[PART_W-1:0];
				if (it.end_of_text)
					broken = 1'b1;
			end
		end
		if (broken) begin
			emit      = 1'b1;
			res       = '0;
			res.error = 1'b1;
			seq_left  = '0;
			seq_bits  = '0;
			seq_len   = '0;
		end
	endtask

	// Predict on byte transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin : watch
		bit        emit;
		out_item_t res;
		out_item_t want;
		if (!arst_n) begin
			seq_left = '0;
			seq_bits = '0;
			seq_len  = '0;
			expected_chars.delete();
			pending  = 0;
		end else begin
			if (push && !full) begin
				decode_byte(item, emit, res);
				if (emit)
					expected_chars.insert(expected_chars.size(), res);
			end
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result cp=%h len=%0d err=%b",
							$realtime, result.code_point, result.seq_length, result.error);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (result.code_point !== want.code_point ||
					    result.seq_length !== want.seq_length ||
					    result.error !== want.error) begin
						if (fail_count < 10)
							$display("%0t: expected cp=%h len=%0d err=%b, got %h %0d %b",
								$realtime, want.code_point, want.seq_length, want.error,
								result.code_point, result.seq_length, result.error);
						fail_count++;
					end
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

@@ test/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
	import u8d_pkg::*;

	localparam int unsigned N_ITEMS      = 1750;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned LIMIT_CYCLES = 100000;

	// Directed bytes as {end_of_text, byte}
	localparam logic [8:0] DIRECTED [26] = '{
		9'h000, 9'h17F,                   // ASCII extremes, end flag ignored
		9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF,   // two-byte sequences
		9'h0E2, 9'h082, 9'h0AC,           // three-byte sequence
		9'h0F0, 9'h09F, 9'h098, 9'h080,   // four-byte sequence
		9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,   // largest value, end on the last byte
		9'h080, 9'h0BF, 9'h0F8, 9'h1FF,   // invalid leads, last one flagged end
		9'h0C3, 9'h041,                   // continuation missing, byte dropped
		9'h1E2,                           // string ends on the lead
		9'h0F0, 9'h19F                    // string ends mid-sequence
	};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push   = 1'b0;
	logic       full;
	in_item_t   item   = '0;
	logic       empty;
	logic       pop    = 1'b0;
	out_item_t  result;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned sent      = 0;
	int unsigned hold_left = 0;
	bit          hold_req  = 1'b0;
	bit          idle_on   = 1'b1;

	utf8_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	utf8_stream_decoder_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random idling, long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !(idle_on && $urandom_range(99) < 16);
			end
		end
	end

	// Offer one byte, return after the edge of its transfer
	task automatic put_byte(input logic [7:0] b, input logic eot);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{byte_in: b, end_of_text: eot};
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
	endtask

	// Hold the byte side until every predicted result has arrived
	task automatic wait_drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] lead_byte(input int unsigned len);
		case (len)
			1:       lead_byte = {1'b0, 7'($urandom)};
			2:       lead_byte = {3'b110, 5'($urandom)};
			3:       lead_byte = {4'b1110, 4'($urandom)};
			default: lead_byte = {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// Mostly well-formed characters, some broken sequences, some raw noise
	task automatic send_random();
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		logic [7:0]  b;
		pick = $urandom_range(99);
		if (pick < 75) begin
			len = $urandom_range(1, 4);
			put_byte(lead_byte(len), len == 1 && $urandom_range(15) == 0);
			for (int unsigned k = 1; k < len; k++)
				put_byte({2'b10, 6'($urandom)}, k == len - 1 && $urandom_range(15) == 0);
		end else if (pick < 90) begin
			len = $urandom_range(2, 4);
			n   = $urandom_range(0, len - 2);
			if ($urandom_range(1)) begin
				// string ends before the sequence completes
				put_byte(lead_byte(len), n == 0);
				for (int unsigned k = 1; k <= n; k++)
					put_byte({2'b10, 6'($urandom)}, k == n);
			end else begin
				// a non-continuation breaks the sequence
				put_byte(lead_byte(len), 1'b0);
				for (int unsigned k = 1; k <= n; k++)
					put_byte({2'b10, 6'($urandom)}, 1'b0);
				b = 8'($urandom);
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				put_byte(b, 1'($urandom));
			end
		end else begin
			put_byte(8'($urandom), 1'($urandom));
		end
	endtask

	// Stimulus and verdict
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			put_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		wait_drain();

		while (sent < 600)
			send_random();

		// result side holds off while bytes keep coming
		hold_req = 1'b1;
		while (sent < 800)
			send_random();
		wait_drain();

		// stretch with no idling on either side
		idle_on = 1'b0;
		while (sent < 1300)
			send_random();
		idle_on = 1'b1;

		while (sent < N_ITEMS)
			send_random();

		wait_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_fifo.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_stream_decoder.sv
test/utf8_stream_decoder_chk.sv
test/utf8_stream_decoder_tb.sv
